>>> rtl/assert_macros.svh
// assertion macros used by biquad_lowpass_filter_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/bqlp_pkg.sv
// package with formats, register indexes and helpers of the biquad low-pass section
package bqlp_pkg;

	// fixed formats
	localparam int DELAY_BITS = 40;
	localparam int DELAY_FRAC = 16;
	localparam int COEF_BITS  = 24;
	localparam int PROD_W     = COEF_BITS + DELAY_BITS;
	localparam int ACC_W      = PROD_W + 2;

	// parameter defaults
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 20;

	// configuration registers
	localparam int NUM_REGS  = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0  = 3'd0,
		REG_B1  = 3'd1,
		REG_B2  = 3'd2,
		REG_A1  = 3'd3,
		REG_A2  = 3'd4,
		REG_INV = 3'd5
	} reg_idx_t;

	// commands
	localparam logic CMD_APPLY   = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic signed [DELAY_BITS-1:0] delay_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	localparam acc_t DLY_MAX = {{(ACC_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
	localparam acc_t DLY_MIN = ~DLY_MAX;

	// saturate a wide value to the delay range
	function automatic delay_t sat_delay(input acc_t v);
		delay_t r;
		if (v > DLY_MAX) begin
			r = DLY_MAX[DELAY_BITS-1:0];
		end else if (v < DLY_MIN) begin
			r = DLY_MIN[DELAY_BITS-1:0];
		end else begin
			r = v[DELAY_BITS-1:0];
		end
		return r;
	endfunction

	// true when a wide value lies outside the delay range
	function automatic logic out_of_delay(input acc_t v);
		return (v > DLY_MAX) || (v < DLY_MIN);
	endfunction

endpackage

>>> rtl/biquad_lowpass_filter_top.sv
// biquad low-pass section: config registers, sequencer and one shared multiplier
// steps: an apply runs A1, A2, W, B2, B0, Y0 and OUT, a preload runs PRE_MUL
// and PRE_WR first; OUT waits while the result register is held downstream
// one item at a time: a new input is taken only in IDLE, since the five dependent
// products (six with preload) go through the single 24x40 multiplier in turn
// reset: arst_n clears delays, sequencer and output valid, coefficients take defaults
`include "assert_macros.svh"

module biquad_lowpass_filter_top
	import bqlp_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [COEF_BITS-1:0]                 cfg_data,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // [SAMPLE_BITS-1:0] sample_in
	input  logic                                 s_tuser,  // [0] cmd
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // [SAMPLE_BITS-1:0] sample_out
	output logic                                 m_tuser   // [0] fallback_used
);

	localparam int TDATA_W = ((SAMPLE_BITS+7)/8)*8;
	localparam int PRE_SH  = (COEF_FRAC_BITS >= DELAY_FRAC) ? COEF_FRAC_BITS - DELAY_FRAC : 0;
	localparam int PRE_UP  = (COEF_FRAC_BITS < DELAY_FRAC) ? DELAY_FRAC - COEF_FRAC_BITS : 0;

	localparam acc_t  HALF_CF  = acc_t'(1) <<< (COEF_FRAC_BITS-1);
	localparam acc_t  HALF_PRE = (PRE_SH > 0) ? (acc_t'(1) <<< (PRE_SH-1)) : acc_t'(0);
	localparam acc_t  HALF_OUT = acc_t'(1) <<< (DELAY_FRAC-1);
	localparam acc_t  SMP_MAX  = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam acc_t  SMP_MIN  = ~SMP_MAX;
	localparam coef_t COEF_ONE = coef_t'(PROD_W'(1) << COEF_FRAC_BITS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE_MUL,
		S_PRE_WR,
		S_A1,
		S_A2,
		S_W,
		S_B2,
		S_B0,
		S_Y0,
		S_OUT
	} state_t;

	state_t state_q;

	coef_t  coef_q [NUM_REGS];
	logic   cmd_q;
	logic   fb_q;
	delay_t d1_q;
	delay_t d2_q;
	delay_t w_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	prod_t  prod_q;
	acc_t   acc_q;

	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] m_data_q;
	logic                   m_fb_q;

	coef_t  mul_c;
	delay_t mul_d;
	acc_t   x_ext;
	acc_t   xd_wide;
	delay_t xd;
	acc_t   prod_ext;
	acc_t   prod_rnd;
	acc_t   pre_val;
	delay_t pre_sat;
	acc_t   w_next;
	logic   w_ovf;
	acc_t   y_rnd;
	logic [SAMPLE_BITS-1:0] y_sat;
	logic   out_free;

	// config registers, always ready, out-of-range index ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_B0]  <= COEF_ONE;
			coef_q[REG_B1]  <= '0;
			coef_q[REG_B2]  <= '0;
			coef_q[REG_A1]  <= '0;
			coef_q[REG_A2]  <= '0;
			coef_q[REG_INV] <= COEF_ONE;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_c = coef_q[REG_B0];
		mul_d = w_q;
		unique case (state_q)
			S_PRE_MUL: begin
				mul_c = coef_q[REG_INV];
				mul_d = delay_t'(x_q);
			end
			S_A1: begin
				mul_c = coef_q[REG_A1];
				mul_d = d1_q;
			end
			S_A2: begin
				mul_c = coef_q[REG_A2];
				mul_d = d2_q;
			end
			S_W: begin
				mul_c = coef_q[REG_B1];
				mul_d = d1_q;
			end
			S_B2: begin
				mul_c = coef_q[REG_B2];
				mul_d = d2_q;
			end
			default: begin
				mul_c = coef_q[REG_B0];
				mul_d = w_q;
			end
		endcase
	end

	// product rounding, sample scaling, overflow checks and output saturation
	always_comb begin
		x_ext    = acc_t'(x_q);
		xd_wide  = x_ext <<< DELAY_FRAC;
		xd       = sat_delay(xd_wide);
		prod_ext = acc_t'(prod_q);
		prod_rnd = (prod_ext + HALF_CF) >>> COEF_FRAC_BITS;
		pre_val  = ((prod_ext + HALF_PRE) >>> PRE_SH) <<< PRE_UP;
		pre_sat  = sat_delay(pre_val);
		w_next   = acc_q - prod_rnd;
		w_ovf    = out_of_delay(w_next);
		y_rnd    = (acc_q + HALF_OUT) >>> DELAY_FRAC;
		if (y_rnd > SMP_MAX) begin
			y_sat = SMP_MAX[SAMPLE_BITS-1:0];
		end else if (y_rnd < SMP_MIN) begin
			y_sat = SMP_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_rnd[SAMPLE_BITS-1:0];
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= mul_c * mul_d;
		if (s_tvalid && s_tready) begin
			x_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		unique case (state_q)
			S_A1: acc_q <= xd_wide;
			S_A2: acc_q <= w_next;
			S_W:  w_q   <= w_ovf ? xd : w_next[DELAY_BITS-1:0];
			S_B2: acc_q <= prod_rnd;
			S_B0: acc_q <= acc_q + prod_rnd;
			S_Y0: acc_q <= acc_q + prod_rnd;
			default: ;
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;

	// sequencer, delay line and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_APPLY;
			fb_q       <= 1'b0;
			d1_q       <= '0;
			d2_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
			m_fb_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						state_q <= (s_tuser == CMD_PRELOAD) ? S_PRE_MUL : S_A1;
					end
				end
				S_PRE_MUL: state_q <= S_PRE_WR;
				S_PRE_WR: begin
					d1_q    <= pre_sat;
					d2_q    <= pre_sat;
					state_q <= S_A1;
				end
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_W;
				S_W: begin
					fb_q    <= w_ovf;
					state_q <= S_B2;
				end
				S_B2: state_q <= S_B0;
				S_B0: state_q <= S_Y0;
				S_Y0: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= y_sat;
						m_fb_q     <= fb_q;
						d2_q       <= d1_q;
						d1_q       <= w_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_data_q);
	assign m_tuser  = m_fb_q;

	// a new result only comes out of the final sequencer step
	`ASSERT_AT(a_result_from_out, clk, arst_n, $rose(m_tvalid) |-> $past(state_q) == S_OUT)
	// a pending result is never overwritten
	`ASSERT_AT(a_hold_when_full, clk, arst_n,
		(state_q == S_OUT && m_tvalid && !m_tready) |=> (state_q == S_OUT))
	// preload leaves both delays equal
	`ASSERT_AT(a_preload_equal, clk, arst_n, (state_q == S_PRE_WR) |=> (d1_q == d2_q))
	// preload path only runs for the preload command
	`ASSERT_NEVER(a_preload_cmd, clk, arst_n, (state_q == S_PRE_MUL) && (cmd_q != CMD_PRELOAD))

endmodule
